// File: hw/rtl/tbh_pkg.sv
`timescale 1ns / 1ps

package tbh_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int HEIGHT_WIDTH = 32;

  // Register stages in the front arithmetic pipeline.
  localparam int FRONT_STAGES = 6;

  // Entries in the queue between front and back; at least FRONT_STAGES + 2 keeps one
  // transaction per cycle flowing while the output is not stalled.
  localparam int QUEUE_DEPTH = 8;

endpackage

// File: hw/rtl/triangle_barycentric_height.sv
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// input    in_valid, in_stall   vert_{a,b,c}_{x,y,h}, query_x, query_y
// output   out_valid, out_stall height, degenerate
//
// One transaction per cycle is accepted and delivered when neither side stalls.
// A transaction passes the front pipeline, the queue and the back's divider; the
// divider retires one quotient bit per pipeline stage.
// Reset clears all valid flags and the queue pointers; payload is not reset.
// A stall of a valid output freezes the divider; the front keeps filling the
// queue and raises in_stall only when the queue plus in-flight items is full.

module triangle_barycentric_height #(
  parameter int COORD_WIDTH = tbh_pkg::COORD_WIDTH,
  parameter int HEIGHT_WIDTH = tbh_pkg::HEIGHT_WIDTH,
  parameter int QUEUE_DEPTH = tbh_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] vert_a_x,
  input  logic signed [COORD_WIDTH-1:0] vert_a_y,
  input  logic signed [HEIGHT_WIDTH-1:0] vert_a_h,
  input  logic signed [COORD_WIDTH-1:0] vert_b_x,
  input  logic signed [COORD_WIDTH-1:0] vert_b_y,
  input  logic signed [HEIGHT_WIDTH-1:0] vert_b_h,
  input  logic signed [COORD_WIDTH-1:0] vert_c_x,
  input  logic signed [COORD_WIDTH-1:0] vert_c_y,
  input  logic signed [HEIGHT_WIDTH-1:0] vert_c_h,
  input  logic signed [COORD_WIDTH-1:0] query_x,
  input  logic signed [COORD_WIDTH-1:0] query_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [HEIGHT_WIDTH-1:0] height,
  output logic                          degenerate
);

  localparam int XW = 2 * (COORD_WIDTH + 1) + 1;
  localparam int NW = HEIGHT_WIDTH + 1 + XW + 2;
  localparam int QW = NW + XW + 1;
  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam int BW = $clog2(tbh_pkg::FRONT_STAGES + 1);

  logic                 take, push, f_degen, q_pop, q_degen;
  logic signed [NW-1:0] f_num, q_num;
  logic signed [XW-1:0] f_den, q_den;
  logic [BW-1:0]        busy;
  logic [LW-1:0]        level;
  logic [QW-1:0]        q_rdata;
  logic [LW:0]          credit;
  logic [HEIGHT_WIDTH-1:0] h_out;

  assign credit = (LW + 1)'(level) + (LW + 1)'(busy);
  assign in_stall = credit >= (LW + 1)'(QUEUE_DEPTH);
  assign take = in_valid && !in_stall;

  tbh_front #(.CW(COORD_WIDTH), .HW(HEIGHT_WIDTH)) u_front (
    .clk(clk), .rst(rst), .take(take),
    .a_x(vert_a_x), .a_y(vert_a_y), .a_h(vert_a_h),
    .b_x(vert_b_x), .b_y(vert_b_y), .b_h(vert_b_h),
    .c_x(vert_c_x), .c_y(vert_c_y), .c_h(vert_c_h),
    .q_x(query_x), .q_y(query_y),
    .push(push), .num(f_num), .den(f_den), .degen(f_degen), .busy(busy)
  );

  tbh_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push),
    .wdata({f_num, f_den, f_degen}),
    .pop(q_pop), .rdata(q_rdata), .level(level)
  );

  assign q_num = q_rdata[QW-1:XW+1];
  assign q_den = q_rdata[XW:1];
  assign q_degen = q_rdata[0];

  tbh_back #(.CW(COORD_WIDTH), .HW(HEIGHT_WIDTH)) u_back (
    .clk(clk), .rst(rst), .avail(level != '0),
    .num(q_num), .den(q_den), .degen(q_degen), .pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .height(h_out), .degenerate(degenerate)
  );

  assign height = h_out;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !q_pop && level == LW'(QUEUE_DEPTH)))
    else $error("queue written while full");

  a_credit: assert property (@(posedge clk) disable iff (rst)
    credit <= (LW + 1)'(QUEUE_DEPTH))
    else $error("queue plus front pipeline exceeds queue depth");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !q_pop)
    else $error("queue popped while the output is stalled");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (level != '0))
    else $error("queue popped while empty");
`endif

endmodule

// File: hw/rtl/tbh_front.sv
`timescale 1ns / 1ps

module tbh_front #(
  parameter int CW = tbh_pkg::COORD_WIDTH,
  parameter int HW = tbh_pkg::HEIGHT_WIDTH,
  localparam int DW = CW + 1,
  localparam int PW = 2 * DW,
  localparam int XW = PW + 1,
  localparam int HDW = HW + 1,
  localparam int XL = (XW + 1) / 2,
  localparam int XH = XW - XL,
  localparam int NW = HDW + XW + 2,
  localparam int BW = $clog2(tbh_pkg::FRONT_STAGES + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic signed [CW-1:0] a_x,
  input  logic signed [CW-1:0] a_y,
  input  logic signed [HW-1:0] a_h,
  input  logic signed [CW-1:0] b_x,
  input  logic signed [CW-1:0] b_y,
  input  logic signed [HW-1:0] b_h,
  input  logic signed [CW-1:0] c_x,
  input  logic signed [CW-1:0] c_y,
  input  logic signed [HW-1:0] c_h,
  input  logic signed [CW-1:0] q_x,
  input  logic signed [CW-1:0] q_y,
  output logic                 push,
  output logic signed [NW-1:0] num,
  output logic signed [XW-1:0] den,
  output logic                 degen,
  output logic [BW-1:0]        busy
);

  logic [tbh_pkg::FRONT_STAGES-1:0] vld;

  logic signed [DW-1:0]  e0x, e0y, e1x, e1y, e2x, e2y;
  logic signed [HDW-1:0] h1a, h1b, h1c, h2a, h2b, h2c, h3a, h3b, h3c;
  logic signed [PW-1:0]  p00, p01, pv0, pv1, pw0, pw1;
  logic signed [XW-1:0]  xd, xv, xw, d4, d5;
  logic signed [HDW+XL:0]   lo_a, lo_b, lo_c;
  logic signed [HDW+XH-1:0] hi_a, hi_b, hi_c;
  logic signed [NW-1:0]  t_a, t_b, t_c;
  logic                  z4, z5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[tbh_pkg::FRONT_STAGES-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    e0x <= DW'(b_x) - DW'(a_x);
    e0y <= DW'(b_y) - DW'(a_y);
    e1x <= DW'(c_x) - DW'(a_x);
    e1y <= DW'(c_y) - DW'(a_y);
    e2x <= DW'(q_x) - DW'(a_x);
    e2y <= DW'(q_y) - DW'(a_y);
    h1a <= HDW'(a_h);
    h1b <= HDW'(b_h) - HDW'(a_h);
    h1c <= HDW'(c_h) - HDW'(a_h);

    p00 <= e0x * e1y;
    p01 <= e0y * e1x;
    pv0 <= e2x * e1y;
    pv1 <= e2y * e1x;
    pw0 <= e0x * e2y;
    pw1 <= e0y * e2x;
    h2a <= h1a;
    h2b <= h1b;
    h2c <= h1c;

    xd <= XW'(p00) - XW'(p01);
    xv <= XW'(pv0) - XW'(pv1);
    xw <= XW'(pw0) - XW'(pw1);
    h3a <= h2a;
    h3b <= h2b;
    h3c <= h2c;

    lo_a <= h3a * $signed({1'b0, xd[XL-1:0]});
    lo_b <= h3b * $signed({1'b0, xv[XL-1:0]});
    lo_c <= h3c * $signed({1'b0, xw[XL-1:0]});
    hi_a <= h3a * $signed(xd[XW-1:XL]);
    hi_b <= h3b * $signed(xv[XW-1:XL]);
    hi_c <= h3c * $signed(xw[XW-1:XL]);
    d4 <= xd;
    z4 <= (xd == '0);

    t_a <= (NW'(hi_a) <<< XL) + NW'(lo_a);
    t_b <= (NW'(hi_b) <<< XL) + NW'(lo_b);
    t_c <= (NW'(hi_c) <<< XL) + NW'(lo_c);
    d5 <= d4;
    z5 <= z4;

    num <= t_a + t_b + t_c;
    den <= d5;
    degen <= z5;
  end

  assign push = vld[tbh_pkg::FRONT_STAGES-1];
  assign busy = BW'($countones(vld));

endmodule

// File: hw/rtl/tbh_queue.sv
`timescale 1ns / 1ps

module tbh_queue #(
  parameter int W = 8,
  parameter int DEPTH = tbh_pkg::QUEUE_DEPTH,
  localparam int AW = $clog2(DEPTH),
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [W-1:0]  wdata,
  input  logic          pop,
  output logic [W-1:0]  rdata,
  output logic [LW-1:0] level
);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr, rptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      level <= level + LW'(push) - LW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  assign rdata = mem[rptr];

endmodule

// File: hw/rtl/tbh_back.sv
`timescale 1ns / 1ps

module tbh_back #(
  parameter int CW = tbh_pkg::COORD_WIDTH,
  parameter int HW = tbh_pkg::HEIGHT_WIDTH,
  localparam int DW = CW + 1,
  localparam int XW = 2 * DW + 1,
  localparam int NW = HW + 1 + XW + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 avail,
  input  logic signed [NW-1:0] num,
  input  logic signed [XW-1:0] den,
  input  logic                 degen,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [HW-1:0]        height,
  output logic                 degenerate
);

  localparam logic [HW:0] POS_LIM = {2'b00, {(HW - 1){1'b1}}};
  localparam logic [HW:0] NEG_LIM = {2'b01, {(HW - 1){1'b0}}};

  logic          en;
  logic          v0, neg0, dg0;
  logic [NW-1:0] nm0;
  logic [XW-1:0] dm0;

  logic          vs   [HW+1];
  logic          negs [HW+1];
  logic          dgs  [HW+1];
  logic          ovfs [HW+1];
  logic [XW-1:0] dms  [HW+1];
  logic [NW-1:0] rems [HW+1];
  logic [HW-1:0] qs   [HW+1];
  logic [NW:0]   subs [HW];

  logic          rnd;
  logic [HW:0]   qr;

  assign en = !(out_valid && out_stall);
  assign pop = en && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      vs[0] <= 1'b0;
    end else if (en) begin
      v0 <= pop;
      vs[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm0 <= num[NW-1] ? NW'(-num) : NW'(num);
      dm0 <= den[XW-1] ? XW'(-den) : XW'(den);
      neg0 <= num[NW-1] ^ den[XW-1];
      dg0 <= degen;

      ovfs[0] <= {1'b0, nm0} >= ((NW + 1)'(dm0) << HW);
      rems[0] <= nm0;
      qs[0] <= '0;
      dms[0] <= dm0;
      negs[0] <= neg0;
      dgs[0] <= dg0;
    end
  end

  for (genvar j = 0; j < HW; j++) begin : g_div
    assign subs[j] = (NW + 1)'(dms[j]) << (HW - 1 - j);

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[j+1] <= 1'b0;
      end else if (en) begin
        vs[j+1] <= vs[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rems[j]} >= subs[j]) begin
          rems[j+1] <= rems[j] - subs[j][NW-1:0];
          qs[j+1] <= qs[j] | (HW'(1) << (HW - 1 - j));
        end else begin
          rems[j+1] <= rems[j];
          qs[j+1] <= qs[j];
        end
        dms[j+1] <= dms[j];
        negs[j+1] <= negs[j];
        dgs[j+1] <= dgs[j];
        ovfs[j+1] <= ovfs[j];
      end
    end
  end

  assign rnd = {rems[HW], 1'b0} >= (NW + 1)'(dms[HW]);
  assign qr = (HW + 1)'(qs[HW]) + (HW + 1)'(rnd);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vs[HW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degenerate <= dgs[HW];
      if (dgs[HW]) begin
        height <= '0;
      end else if (!negs[HW]) begin
        height <= (ovfs[HW] || qr > POS_LIM) ? POS_LIM[HW-1:0] : qr[HW-1:0];
      end else begin
        height <= (ovfs[HW] || qr > NEG_LIM) ? NEG_LIM[HW-1:0] : HW'(-qr);
      end
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

class height_scoreboard;
  logic signed [31:0] exp_height[$];
  logic exp_degen[$];
  int errors = 0;

  function automatic logic signed [127:0] cross2(logic signed [127:0] ax,
      logic signed [127:0] ay, logic signed [127:0] bx, logic signed [127:0] by);
    return ax * by - ay * bx;
  endfunction

  function void note_input(logic signed [23:0] ax, logic signed [23:0] ay,
      logic signed [31:0] ah, logic signed [23:0] bx, logic signed [23:0] by,
      logic signed [31:0] bh, logic signed [23:0] cx, logic signed [23:0] cy,
      logic signed [31:0] ch, logic signed [23:0] px, logic signed [23:0] py);
    logic signed [127:0] e0x, e0y, e1x, e1y, e2x, e2y, area, vc, wc, num;
    logic [127:0] nm, dm, q, r;
    logic neg;
    logic signed [31:0] eh;
    e0x = bx - ax; e0y = by - ay;
    e1x = cx - ax; e1y = cy - ay;
    e2x = px - ax; e2y = py - ay;
    area = cross2(e0x, e0y, e1x, e1y);
    if (area == 0) begin
      exp_height = {exp_height, 32'sd0};
      exp_degen = {exp_degen, 1'b1};
      return;
    end
    vc = cross2(e2x, e2y, e1x, e1y);
    wc = cross2(e0x, e0y, e2x, e2y);
    num = 128'(signed'(ah)) * area + (128'(signed'(bh)) - ah) * vc
        + (128'(signed'(ch)) - ah) * wc;
    neg = num[127] != area[127];
    nm = num[127] ? -num : num;
    dm = area[127] ? -area : area;
    q = nm / dm;
    r = nm % dm;
    if (r >= dm - r) q = q + 1;
    if (!neg) eh = (q > 128'h7fffffff) ? 32'h7fffffff : q[31:0];
    else eh = (q > 128'h80000000) ? 32'h80000000 : -q[31:0];
    exp_height = {exp_height, eh};
    exp_degen = {exp_degen, 1'b0};
  endfunction

  function void check_result(logic signed [31:0] h, logic d);
    logic signed [31:0] eh;
    logic ed;
    if (exp_height.size() == 0) begin
      $error("result with no transaction pending: height %0d", h);
      errors++;
      return;
    end
    eh = exp_height.pop_front();
    ed = exp_degen.pop_front();
    if (h !== eh) begin
      $error("height expected %0d actual %0d", eh, h);
      errors++;
    end
    if (d !== ed) begin
      $error("degenerate expected %0d actual %0d", ed, d);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int LATENCY = tbh_pkg::FRONT_STAGES + 1 + tbh_pkg::HEIGHT_WIDTH + 3;
  localparam int N_RANDOM = 1030;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 0, rst = 1, in_valid = 0, out_stall = 0;
  logic in_stall, out_valid, degenerate;
  logic signed [tbh_pkg::COORD_WIDTH-1:0] vert_a_x = 0, vert_a_y = 0, vert_b_x = 0;
  logic signed [tbh_pkg::COORD_WIDTH-1:0] vert_b_y = 0, vert_c_x = 0, vert_c_y = 0;
  logic signed [tbh_pkg::COORD_WIDTH-1:0] query_x = 0, query_y = 0;
  logic signed [tbh_pkg::HEIGHT_WIDTH-1:0] vert_a_h = 0, vert_b_h = 0, vert_c_h = 0, height;
  height_scoreboard sb = new();
  bit hold_off = 0;
  int cycles = 0;

  triangle_barycentric_height dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (!rst && in_valid && !in_stall)
      sb.note_input(vert_a_x, vert_a_y, vert_a_h, vert_b_x, vert_b_y, vert_b_h,
                    vert_c_x, vert_c_y, vert_c_h, query_x, query_y);
    if (!rst && out_valid && !out_stall) sb.check_result(height, degenerate);
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [23:0] coord_val(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
    endcase
  endfunction

  task automatic send(logic [23:0] ax, logic [23:0] ay, logic [31:0] ah,
      logic [23:0] bx, logic [23:0] by, logic [31:0] bh, logic [23:0] cx,
      logic [23:0] cy, logic [31:0] ch, logic [23:0] px, logic [23:0] py);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    vert_a_x <= ax; vert_a_y <= ay; vert_a_h <= ah;
    vert_b_x <= bx; vert_b_y <= by; vert_b_h <= bh;
    vert_c_x <= cx; vert_c_y <= cy; vert_c_h <= ch;
    query_x <= px; query_y <= py;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    int m;
    logic [23:0] ax, ay;
    m = $urandom_range(0, 9);
    ax = coord_val(m % 3);
    ay = coord_val((m / 3) % 3);
    if (m == 9)
      send(ax, ay, $urandom, ax + 24'd3, ay + 24'd5, $urandom, ax - 24'd6, ay - 24'd10,
           $urandom, coord_val(1), coord_val(0));
    else
      send(ax, ay, $urandom, coord_val(m % 2), coord_val(1), $urandom,
           coord_val(m % 3), coord_val(m % 2), $urandom, coord_val(m % 3), coord_val(1));
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_off) out_stall <= 1;
      else if ($urandom_range(0, 99) < 30) out_stall <= 1;
      else out_stall <= 0;
    end
  end

  initial begin
    int n;
    repeat (3) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    send(0, 0, 0, 24'd256, 0, 32'd256, 0, 24'd256, 32'd512, 24'd64, 24'd64);
    send(0, 0, 32'h7fffffff, 24'd1, 0, 32'h80000000, 0, 24'd1, 32'h7fffffff, 24'd1, 24'd1);
    send(0, 0, 32'h80000000, 24'd1, 0, 32'h7fffffff, 0, 24'd1, 32'h80000000,
         24'h7fffff, 24'h7fffff);
    send(0, 0, 32'd5, 24'd10, 24'd10, 32'd7, 24'd20, 24'd20, 32'd9, 24'd3, 24'd4);
    send(24'd5, 24'd5, 32'd1, 24'd5, 24'd5, 32'd2, 24'd9, 24'd9, 32'd3, 0, 0);
    send(24'h7fffff, 24'h7fffff, 32'hffffffff, 24'h800000, 24'h800000, 0,
         24'h7fffff, 24'h800000, 32'h7fffffff, 24'h800000, 24'h7fffff);
    send(24'h800000, 24'h7fffff, 32'h12345678, 24'h7fffff, 24'h800000, 32'h87654321,
         24'h800000, 24'h800000, 32'h0, 24'h7fffff, 24'h7fffff);
    send(0, 0, 0, 24'd2, 0, 32'd1, 0, 24'd2, 0, 24'd1, 0);
    send(0, 0, 0, 24'd2, 0, 32'hffffffff, 0, 24'd2, 0, 24'd1, 0);
    send(0, 0, 0, 24'd2, 0, 32'd3, 0, 24'd2, 0, 24'd1, 0);
    send(0, 0, 0, 24'd2, 0, 32'hfffffffd, 0, 24'd2, 0, 24'd1, 0);
    send(24'hffffff, 24'hfffffe, 32'hffff0000, 24'h00aaaa, 24'h555555, 32'h0000ffff,
         24'h555555, 24'h00aaaa, 32'haaaaaaaa, 24'h123456, 24'hedcba9);
    hold_off = 1;
    fork
      begin repeat (150) @(posedge clk); hold_off = 0; end
      for (n = 0; n < 30; n++) send_random();
    join
    for (n = 0; n < N_RANDOM; n++) send_random();
    in_valid <= 0;
    while (sb.exp_height.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
